// File: rtl/core/swls_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding window latency statistics package
// Field widths, operation codes and the bucket record that is kept in memory.
// ----------------------------------------------------------------------------
package swls_pkg;

   localparam int unsigned SEC_W       = 32;
   localparam int unsigned LAT_W       = 32;
   localparam int unsigned SPAN_W      = 6;
   localparam int unsigned CALLS_W     = 32;
   localparam int unsigned SUM_W       = 48;
   localparam int unsigned TOT_CALLS_W = 38;
   localparam int unsigned TOT_SUM_W   = 54;

   typedef enum logic {
      OP_RECORD = 1'b0,
      OP_QUERY  = 1'b1
   } op_type;

   typedef struct packed {
      logic [SEC_W-1:0]   stamp;
      logic [CALLS_W-1:0] calls;
      logic [SUM_W-1:0]   sum;
      logic [LAT_W-1:0]   min_us;
      logic [LAT_W-1:0]   max_us;
   } bucket_type;

   localparam logic [CALLS_W-1:0] CALLS_MAX = '1;
   localparam logic [SUM_W-1:0]   SUM_MAX   = '1;

endpackage

// File: rtl/core/swls_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Request channel interface
// Carries record and query transactions into the statistics unit.
// ----------------------------------------------------------------------------
interface swls_req_if;
   logic                           valid;
   logic                           ready;
   swls_pkg::op_type               op;
   logic [swls_pkg::SEC_W-1:0]     now_sec;
   logic [swls_pkg::LAT_W-1:0]     sample_us;
   logic [swls_pkg::SPAN_W-1:0]    query_span;

   modport source (output valid, op, now_sec, sample_us, query_span, input ready);
   modport sink   (input valid, op, now_sec, sample_us, query_span, output ready);
endinterface

// File: rtl/core/swls_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Response channel interface
// Carries the window statistics produced by a query transaction.
// ----------------------------------------------------------------------------
interface swls_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [swls_pkg::TOT_CALLS_W-1:0]  total_calls;
   logic [swls_pkg::TOT_SUM_W-1:0]    total_sum_us;
   logic [swls_pkg::LAT_W-1:0]        min_us;
   logic [swls_pkg::LAT_W-1:0]        max_us;

   modport source (output valid, total_calls, total_sum_us, min_us, max_us, input ready);
   modport sink   (input valid, total_calls, total_sum_us, min_us, max_us, output ready);
endinterface

// File: rtl/core/sliding_window_latency_stats_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding window latency statistics unit
// Keeps a ring of per-second latency buckets in memory and answers window
// queries over the most recent seconds.
//
// Usage: transactions arrive on req_bus. A record transaction (op = record)
// updates the bucket of its second and produces no response. A query
// transaction (op = query) walks back over up to query_span seconds, limited
// to the bucket count and to second zero, and produces one response on
// rsp_bus with total calls, latency sum, minimum and maximum.
// A record occupies the unit through the index reduction pipeline, the bucket
// memory read and the write back. A query occupies it through the same
// pipeline and a walk over the seconds it visits, and skips the walk
// when no second is visited;
// the walk reads one bucket per cycle from the single memory read port.
// The response is held in an output register, so the next transaction is
// accepted while a response waits. If the receiver stalls, a finished query
// waits until that register is free.
// Reset clears the control state and every bucket valid flag;
// no clearing pass over the memory is needed.
// ----------------------------------------------------------------------------
module sliding_window_latency_stats_unit #(
   parameter int unsigned NUM_BUCKETS = 60
) (
   input  logic       clock,
   input  logic       reset,
   swls_req_if.sink   req_bus,
   swls_rsp_if.source rsp_bus
);

   localparam int unsigned     IDX_W    = $clog2(NUM_BUCKETS);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BUCKETS - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_UPDATE,
      ST_WALK,
      ST_FINISH
   } state_type;

   state_type                            state_ff, state_in;
   swls_pkg::op_type                     op_ff, op_in;
   logic [swls_pkg::SEC_W-1:0]           now_ff, now_in;
   logic [swls_pkg::LAT_W-1:0]           dur_ff, dur_in;
   logic [swls_pkg::SPAN_W-1:0]          visits_ff, visits_in;
   logic [swls_pkg::SPAN_W-1:0]          issued_ff, issued_in;
   logic [IDX_W-1:0]                     idx_ff, idx_in;
   logic [swls_pkg::SEC_W-1:0]           ts_ff, ts_in;
   logic                                 chk_pend_ff, chk_pend_in;
   logic [swls_pkg::SEC_W-1:0]           chk_ts_ff, chk_ts_in;
   logic [swls_pkg::TOT_CALLS_W-1:0]     acc_calls_ff, acc_calls_in;
   logic [swls_pkg::TOT_SUM_W-1:0]       acc_sum_ff, acc_sum_in;
   logic [swls_pkg::LAT_W-1:0]           acc_min_ff, acc_min_in;
   logic [swls_pkg::LAT_W-1:0]           acc_max_ff, acc_max_in;
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic [swls_pkg::TOT_CALLS_W-1:0]     rsp_calls_ff, rsp_calls_in;
   logic [swls_pkg::TOT_SUM_W-1:0]       rsp_sum_ff, rsp_sum_in;
   logic [swls_pkg::LAT_W-1:0]           rsp_min_ff, rsp_min_in;
   logic [swls_pkg::LAT_W-1:0]           rsp_max_ff, rsp_max_in;
   logic [NUM_BUCKETS-1:0]               bucket_valid_ff, bucket_valid_in;

   swls_pkg::bucket_type                 bucket_mem [NUM_BUCKETS];
   swls_pkg::bucket_type                 rd_data_ff;
   logic                                 rd_valid_ff;
   logic                                 rd_en;
   logic [IDX_W-1:0]                     rd_addr;
   logic                                 wr_en;
   swls_pkg::bucket_type                 wr_data;

   logic                                 accept;
   logic                                 mod_done;
   logic [IDX_W-1:0]                     mod_rem;
   logic [swls_pkg::SPAN_W-1:0]          span_lim;
   logic [swls_pkg::SPAN_W-1:0]          req_visits;
   logic                                 rec_hit;
   logic                                 walk_match;
   logic [swls_pkg::SUM_W:0]             sum_ext;
   logic                                 out_free;

   function automatic logic [IDX_W-1:0] prev_idx(input logic [IDX_W-1:0] idx);
      prev_idx = (idx == '0) ? LAST_IDX : idx - 1'b1;
   endfunction

   swls_mod_reduce #(
      .NUM_BUCKETS (NUM_BUCKETS)
   ) u_mod_reduce (
      .clock     (clock),
      .reset     (reset),
      .start     (accept),
      .value     (req_bus.now_sec),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign accept        = req_bus.valid && req_bus.ready;
   assign out_free      = !rsp_valid_ff || rsp_bus.ready;

   // Number of seconds a query visits: the span, limited to the bucket count
   // and to the seconds that exist back to second zero.
   always_comb begin
      if (32'(req_bus.query_span) > 32'(NUM_BUCKETS)) begin
         span_lim = swls_pkg::SPAN_W'(NUM_BUCKETS);
      end else begin
         span_lim = req_bus.query_span;
      end
      if (req_bus.now_sec < 32'(span_lim)) begin
         req_visits = swls_pkg::SPAN_W'(req_bus.now_sec) + 1'b1;
      end else begin
         req_visits = span_lim;
      end
   end

   always_comb begin
      rec_hit    = rd_valid_ff && (rd_data_ff.stamp == now_ff);
      walk_match = rd_valid_ff && (rd_data_ff.stamp == chk_ts_ff);
      sum_ext    = {1'b0, rd_data_ff.sum} + (swls_pkg::SUM_W + 1)'(dur_ff);

      if (rec_hit) begin
         wr_data.stamp  = now_ff;
         wr_data.calls  = (rd_data_ff.calls == swls_pkg::CALLS_MAX) ? rd_data_ff.calls
                                                                    : rd_data_ff.calls + 1'b1;
         wr_data.sum    = sum_ext[swls_pkg::SUM_W] ? swls_pkg::SUM_MAX
                                                   : sum_ext[swls_pkg::SUM_W-1:0];
         wr_data.min_us = (dur_ff < rd_data_ff.min_us) ? dur_ff : rd_data_ff.min_us;
         wr_data.max_us = (dur_ff > rd_data_ff.max_us) ? dur_ff : rd_data_ff.max_us;
      end else begin
         wr_data.stamp  = now_ff;
         wr_data.calls  = swls_pkg::CALLS_W'(1);
         wr_data.sum    = swls_pkg::SUM_W'(dur_ff);
         wr_data.min_us = dur_ff;
         wr_data.max_us = dur_ff;
      end
   end

   always_comb begin
      state_in        = state_ff;
      op_in           = op_ff;
      now_in          = now_ff;
      dur_in          = dur_ff;
      visits_in       = visits_ff;
      issued_in       = issued_ff;
      idx_in          = idx_ff;
      ts_in           = ts_ff;
      chk_pend_in     = chk_pend_ff;
      chk_ts_in       = chk_ts_ff;
      acc_calls_in    = acc_calls_ff;
      acc_sum_in      = acc_sum_ff;
      acc_min_in      = acc_min_ff;
      acc_max_in      = acc_max_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_bus.ready;
      rsp_calls_in    = rsp_calls_ff;
      rsp_sum_in      = rsp_sum_ff;
      rsp_min_in      = rsp_min_ff;
      rsp_max_in      = rsp_max_ff;
      bucket_valid_in = bucket_valid_ff;
      rd_en           = 1'b0;
      rd_addr         = idx_ff;
      wr_en           = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) begin
               op_in        = req_bus.op;
               now_in       = req_bus.now_sec;
               dur_in       = req_bus.sample_us;
               visits_in    = req_visits;
               acc_calls_in = '0;
               acc_sum_in   = '0;
               acc_min_in   = '1;
               acc_max_in   = '0;
               state_in     = ST_REDUCE;
            end
         end
         ST_REDUCE: begin
            if (mod_done) begin
               idx_in = mod_rem;
               if (op_ff == swls_pkg::OP_RECORD) begin
                  rd_en    = 1'b1;
                  rd_addr  = mod_rem;
                  state_in = ST_UPDATE;
               end else if (visits_ff == '0) begin
                  state_in = ST_FINISH;
               end else begin
                  rd_en       = 1'b1;
                  rd_addr     = mod_rem;
                  chk_pend_in = 1'b1;
                  chk_ts_in   = now_ff;
                  ts_in       = now_ff - 1'b1;
                  idx_in      = prev_idx(mod_rem);
                  issued_in   = swls_pkg::SPAN_W'(1);
                  state_in    = ST_WALK;
               end
            end
         end
         ST_UPDATE: begin
            wr_en                   = 1'b1;
            bucket_valid_in[idx_ff] = 1'b1;
            state_in                = ST_IDLE;
         end
         ST_WALK: begin
            if (chk_pend_ff && walk_match) begin
               acc_calls_in = acc_calls_ff + swls_pkg::TOT_CALLS_W'(rd_data_ff.calls);
               acc_sum_in   = acc_sum_ff + swls_pkg::TOT_SUM_W'(rd_data_ff.sum);
               if (rd_data_ff.min_us < acc_min_ff) begin
                  acc_min_in = rd_data_ff.min_us;
               end
               if (rd_data_ff.max_us > acc_max_ff) begin
                  acc_max_in = rd_data_ff.max_us;
               end
            end
            if (issued_ff != visits_ff) begin
               rd_en       = 1'b1;
               rd_addr     = idx_ff;
               chk_pend_in = 1'b1;
               chk_ts_in   = ts_ff;
               ts_in       = ts_ff - 1'b1;
               idx_in      = prev_idx(idx_ff);
               issued_in   = issued_ff + 1'b1;
            end else begin
               chk_pend_in = 1'b0;
               if (!chk_pend_ff) begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_calls_in = acc_calls_ff;
               rsp_sum_in   = acc_sum_ff;
               rsp_min_in   = (acc_calls_ff != '0) ? acc_min_ff : '0;
               rsp_max_in   = (acc_calls_ff != '0) ? acc_max_ff : '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         chk_pend_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         bucket_valid_ff <= '0;
      end else begin
         state_ff        <= state_in;
         chk_pend_ff     <= chk_pend_in;
         rsp_valid_ff    <= rsp_valid_in;
         bucket_valid_ff <= bucket_valid_in;
      end
      op_ff        <= op_in;
      now_ff       <= now_in;
      dur_ff       <= dur_in;
      visits_ff    <= visits_in;
      issued_ff    <= issued_in;
      idx_ff       <= idx_in;
      ts_ff        <= ts_in;
      chk_ts_ff    <= chk_ts_in;
      acc_calls_ff <= acc_calls_in;
      acc_sum_ff   <= acc_sum_in;
      acc_min_ff   <= acc_min_in;
      acc_max_ff   <= acc_max_in;
      rsp_calls_ff <= rsp_calls_in;
      rsp_sum_ff   <= rsp_sum_in;
      rsp_min_ff   <= rsp_min_in;
      rsp_max_ff   <= rsp_max_in;
   end

   // Bucket memory: one write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         bucket_mem[idx_ff] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff  <= bucket_mem[rd_addr];
         rd_valid_ff <= bucket_valid_ff[rd_addr];
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.total_calls  = rsp_calls_ff;
   assign rsp_bus.total_sum_us = rsp_sum_ff;
   assign rsp_bus.min_us       = rsp_min_ff;
   assign rsp_bus.max_us       = rsp_max_ff;

endmodule

// File: rtl/core/swls_mod_reduce.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Second to bucket index reduction
// Two-stage pipeline that reduces a 32-bit second by the bucket count, using a
// reciprocal multiplication followed by one corrective subtraction.
// ----------------------------------------------------------------------------
module swls_mod_reduce #(
   parameter int unsigned NUM_BUCKETS = 60,
   localparam int unsigned IDX_W = $clog2(NUM_BUCKETS)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [swls_pkg::SEC_W-1:0] value,
   output logic                       done,
   output logic [IDX_W-1:0]           remainder
);

   localparam logic [31:0]    RECIP       = 32'((64'd1 << 32) / NUM_BUCKETS);
   localparam logic [IDX_W:0] BUCKETS_EXT = (IDX_W + 1)'(NUM_BUCKETS);

   logic                       s1_valid_ff, s1_valid_in;
   logic [63:0]                s1_prod_ff, s1_prod_in;
   logic [swls_pkg::SEC_W-1:0] s1_value_ff;
   logic                       s2_valid_ff, s2_valid_in;
   logic [IDX_W:0]             s2_raw_ff, s2_raw_in;
   logic [31:0]                qn_low;
   logic [31:0]                diff;

   // The estimated quotient is never above the true one and at most one
   // below it, so the raw remainder stays under twice the bucket count.
   always_comb begin
      s1_valid_in = start;
      s1_prod_in  = 64'(value) * 64'(RECIP);
      qn_low      = 32'(s1_prod_ff[63:32] * 32'(NUM_BUCKETS));
      diff        = s1_value_ff - qn_low;
      s2_valid_in = s1_valid_ff;
      s2_raw_in   = diff[IDX_W:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
      s1_prod_ff  <= s1_prod_in;
      s1_value_ff <= value;
      s2_raw_ff   <= s2_raw_in;
   end

   assign done      = s2_valid_ff;
   assign remainder = (s2_raw_ff >= BUCKETS_EXT) ? IDX_W'(s2_raw_ff - BUCKETS_EXT)
                                                 : s2_raw_ff[IDX_W-1:0];

endmodule
